// ===== rtl/lsp_pkg.sv =====
// Shared constants, codes and types for the bounded LIFO stack with peek.
`default_nettype none

package lsp_pkg;

   // Stack geometry.
   localparam int DEPTH      = 8;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (CNT_W > 4) ? CNT_W : 4;

   // Port widths fixed by the interface.
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_TOP    = 3'd3;
   localparam logic [OP_W-1:0] OP_BOTTOM = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd3;

   // Access request from the stack controller to the entry memory.
   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== rtl/lifo_stack_with_peek.sv =====
// Top level of the bounded LIFO stack with peek: controller plus entry memory.
//
// Usage:
//   Each req_ transaction carries one operation (push, pop, peek at a
//   position counted from the top, read top, read bottom) and gives exactly
//   one rsp_ transaction with the word, a status code, the empty and full
//   flags and the count after the operation.
//   A result passes through the pending stage and then the result register;
//   the memory read issued at acceptance returns its word in the next cycle.
//   Throughput: one transaction per cycle while the receiver keeps up. The
//   entry memory has one write and one read port, and each operation uses
//   at most one of them, once.
//   A push followed directly by a read of the same entry sees the new word,
//   since the write lands before the later read is issued.
//   Reset empties the stack and drops any result not yet taken; memory
//   contents are not cleared, only entries below the count are ever read.
//   When the receiver stalls, the result register holds its transaction and
//   one further request is still accepted into the pending stage; after
//   that req_ready stays low until the result register frees up.
`default_nettype none

module lifo_stack_with_peek (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [lsp_pkg::OP_W-1:0]           req_op,
   input  wire logic signed [lsp_pkg::VALUE_W-1:0] req_data,
   input  wire logic [lsp_pkg::POS_W-1:0]          req_position,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [lsp_pkg::VALUE_W-1:0]      rsp_value,
   output logic [lsp_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                    rsp_is_empty,
   output logic                                    rsp_is_full,
   output logic [lsp_pkg::COUNT_W-1:0]             rsp_count
);
   import lsp_pkg::*;

   mem_req_type            mem_req;
   logic [DATA_WIDTH-1:0]  mem_rd_data;

   // Controller: decode, fill count and result register.
   lsp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_data     (req_data),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .rsp_count    (rsp_count),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data)
   );

   // Entry storage.
   lsp_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/lsp_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module lsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read; both ports act on the rising edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lsp_core.sv =====
// Stack controller: fill count, request decode, pending stage and result register.
`default_nettype none

module lsp_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [lsp_pkg::OP_W-1:0]         req_op,
   input  wire logic signed [lsp_pkg::VALUE_W-1:0] req_data,
   input  wire logic [lsp_pkg::POS_W-1:0]        req_position,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [lsp_pkg::VALUE_W-1:0]    rsp_value,
   output logic [lsp_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   output logic [lsp_pkg::COUNT_W-1:0]           rsp_count,
   output lsp_pkg::mem_req_type                  mem_req,
   input  wire logic [lsp_pkg::DATA_WIDTH-1:0]   mem_rd_data
);
   import lsp_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [CNT_W-1:0]               pend_fill_ff, pend_fill_in;
   logic [STATUS_W-1:0]            pend_status_ff, pend_status_in;
   logic signed [VALUE_W-1:0]      pend_value_ff, pend_value_in;
   logic                           pend_read_ff, pend_read_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]            rsp_status_ff, rsp_status_in;
   logic                           rsp_is_empty_ff, rsp_is_empty_in;
   logic                           rsp_is_full_ff, rsp_is_full_in;
   logic [COUNT_W-1:0]             rsp_count_ff, rsp_count_in;

   logic                           out_free;
   logic                           accept;
   logic                           finish;
   logic [CMP_W-1:0]               pos_ext;
   logic [CMP_W-1:0]               fill_ext;
   logic [CMP_W-1:0]               peek_diff;
   logic [CNT_W-1:0]               fill_dec;
   logic signed [DATA_WIDTH-1:0]   rd_word;

   // Handshake: the result register frees up when empty or being taken.
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == S_IDLE) || out_free;
      accept    = req_valid && req_ready;
      finish    = (state_ff == S_BUSY) && out_free;
   end

   // Request decode: memory access, new fill count and pending result.
   always_comb begin
      pos_ext   = CMP_W'(req_position);
      fill_ext  = CMP_W'(fill_ff);
      peek_diff = fill_ext - pos_ext;
      fill_dec  = fill_ff - CNT_W'(1);

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = fill_ff[ADDR_W-1:0];
      mem_req.wr_data = DATA_WIDTH'(req_data);
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = fill_dec[ADDR_W-1:0];

      fill_in        = fill_ff;
      pend_status_in = ST_OK;
      pend_value_in  = '0;
      pend_read_in   = 1'b0;

      unique case (req_op)
         OP_PUSH: begin
            if (fill_ff == FULL_COUNT) begin
               pend_status_in = ST_OVERFLOW;
            end else begin
               mem_req.wr_en = accept;
               fill_in       = fill_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (fill_ff == '0) begin
               pend_status_in = ST_EMPTY;
            end else begin
               mem_req.rd_en = accept;
               pend_read_in  = 1'b1;
               fill_in       = fill_dec;
            end
         end
         OP_PEEK: begin
            if ((req_position == '0) || (pos_ext > fill_ext)) begin
               pend_status_in = ST_BAD_POS;
               pend_value_in  = '1;
            end else begin
               mem_req.rd_en   = accept;
               mem_req.rd_addr = peek_diff[ADDR_W-1:0];
               pend_read_in    = 1'b1;
            end
         end
         OP_TOP: begin
            if (fill_ff == '0) begin
               pend_status_in = ST_EMPTY;
            end else begin
               mem_req.rd_en = accept;
               pend_read_in  = 1'b1;
            end
         end
         OP_BOTTOM: begin
            if (fill_ff == '0) begin
               pend_status_in = ST_EMPTY;
            end else begin
               mem_req.rd_en   = accept;
               mem_req.rd_addr = '0;
               pend_read_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      pend_fill_in = fill_in;
      if (!accept) begin
         fill_in = fill_ff;
      end
   end

   // Result assembly: the memory word arrives in the cycle after the read is issued.
   always_comb begin
      rd_word         = mem_rd_data;
      rsp_value_in    = pend_read_ff ? VALUE_W'(rd_word) : pend_value_ff;
      rsp_status_in   = pend_status_ff;
      rsp_is_empty_in = (pend_fill_ff == '0);
      rsp_is_full_in  = (pend_fill_ff == FULL_COUNT);
      rsp_count_in    = COUNT_W'(pend_fill_ff);

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (accept) begin
         state_in = S_BUSY;
      end else if (finish) begin
         state_in = S_IDLE;
      end else begin
         state_in = state_ff;
      end
   end

   // State, fill count and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      if (accept) begin
         pend_fill_ff   <= pend_fill_in;
         pend_status_ff <= pend_status_in;
         pend_value_ff  <= pend_value_in;
         pend_read_ff   <= pend_read_in;
      end

      if (finish) begin
         rsp_value_ff    <= rsp_value_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_is_empty_ff <= rsp_is_empty_in;
         rsp_is_full_ff  <= rsp_is_full_in;
         rsp_count_ff    <= rsp_count_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/lsp_checker.sv =====
// Port-level checks for the LIFO stack, bound to the top level.
`default_nettype none

module lsp_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic signed [lsp_pkg::VALUE_W-1:0] rsp_value,
   input  wire logic [lsp_pkg::STATUS_W-1:0]       rsp_status,
   input  wire logic                               rsp_is_empty,
   input  wire logic                               rsp_is_full
);
   import lsp_pkg::*;

   // Reset drops any waiting result.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result still valid after reset");

   // A refused push only happens on a full stack, which stays full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OVERFLOW)) |-> rsp_is_full)
      else $error("overflow reported on a stack that is not full");

   // An empty status comes with an empty stack and a zero word.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_is_empty && (rsp_value == '0)))
      else $error("empty status with entries held or a non-zero word");

   // A peek out of range returns all ones.
   a_bad_pos_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_BAD_POS)) |-> (rsp_value == -1))
      else $error("invalid peek did not return minus one");

   // A stalled result holds its word.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("result changed while stalled");

endmodule

bind lifo_stack_with_peek lsp_checker u_lsp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_value    (rsp_value),
   .rsp_status   (rsp_status),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full)
);

`default_nettype wire

// ===== test/lifo_stack_with_peek_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded LIFO stack with peek, with random handshake stalls.

module lifo_stack_with_peek_tb;
   import lsp_pkg::*;

   // Opcodes above read-bottom have no operation behind them.
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_BOTTOM + 3'd1;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

   localparam int RANDOM_OPS     = 1250;
   localparam int IDLE_PERCENT   = 24;
   localparam int HOLDOFF_AT     = 300;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int STEADY_FROM    = 600;
   localparam int STEADY_TO      = 800;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] data;
      logic [POS_W-1:0]          position;
      bit                        drain_first;
   } stack_req_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
      logic                      is_empty;
      logic                      is_full;
      logic [COUNT_W-1:0]        count;
   } stack_rsp_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OP_W-1:0]           req_op;
   logic signed [VALUE_W-1:0] req_data;
   logic [POS_W-1:0]          req_position;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;
   logic [COUNT_W-1:0]        rsp_count;

   // Pending requests, and the results expected in order of acceptance.
   stack_req_type stack_requests[$];
   stack_rsp_type awaited_results[$];

   // Shadow copy of the stack contents, updated as each request is accepted.
   logic [DATA_WIDTH-1:0] shadow_words[DEPTH];
   int                    shadow_fill;

   int  planned_fill;
   int  req_accepted;
   int  error_count;
   bit  req_taken;
   bit  holdoff_done;
   int  hold_left;
   int  quiet_cycles;
   logic steady;

   assign steady = (req_accepted >= STEADY_FROM) && (req_accepted < STEADY_TO);

   lifo_stack_with_peek dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_data     (req_data),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .rsp_count    (rsp_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Applies one request to the shadow stack and returns the result it should give.
   function automatic stack_rsp_type apply_stack_op(input stack_req_type req);
      stack_rsp_type res;
      res.value  = '0;
      res.status = ST_OK;
      case (req.op)
         OP_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = DATA_WIDTH'(req.data);
               shadow_fill++;
            end
         end
         OP_POP: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_fill--;
               res.value = VALUE_W'($signed(shadow_words[shadow_fill]));
            end
         end
         OP_PEEK: begin
            if (req.position == '0 || int'(req.position) > shadow_fill) begin
               res.status = ST_BAD_POS;
               res.value  = -1;
            end else begin
               res.value = VALUE_W'($signed(shadow_words[shadow_fill - int'(req.position)]));
            end
         end
         OP_TOP: begin
            if (shadow_fill == 0)
               res.status = ST_EMPTY;
            else
               res.value = VALUE_W'($signed(shadow_words[shadow_fill - 1]));
         end
         OP_BOTTOM: begin
            if (shadow_fill == 0)
               res.status = ST_EMPTY;
            else
               res.value = VALUE_W'($signed(shadow_words[0]));
         end
         default: begin
         end
      endcase
      res.is_empty = (shadow_fill == 0);
      res.is_full  = (shadow_fill == DEPTH);
      res.count    = COUNT_W'(shadow_fill);
      return res;
   endfunction

   // Queues one request and keeps track of the fill it will leave behind.
   task automatic queue_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] data,
                           input logic [POS_W-1:0] position);
      stack_req_type req;
      req.op          = op;
      req.data        = data;
      req.position    = position;
      req.drain_first = 1'b0;
      stack_requests.push_back(req);
      if (op == OP_PUSH && planned_fill < DEPTH)
         planned_fill++;
      else if (op == OP_POP && planned_fill > 0)
         planned_fill--;
   endtask

   // Marks a point where the sender waits until every result has come back.
   task automatic queue_pause();
      stack_req_type req;
      req.op          = OP_PUSH;
      req.data        = '0;
      req.position    = '0;
      req.drain_first = 1'b1;
      stack_requests.push_back(req);
   endtask

   // Random requests in runs that favour filling, draining or a mix of both.
   task automatic queue_random_ops();
      int                        mode;
      int                        pick;
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] data;
      logic [POS_W-1:0]          position;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 16 == 0)
            mode = $urandom_range(2);
         if (n == RANDOM_OPS / 2)
            queue_pause();
         pick = $urandom_range(99);
         if (pick < 3)
            op = OP_W'($urandom_range(int'(OP_SPARE_LAST), int'(OP_SPARE_FIRST)));
         else if (pick < (mode == 0 ? 60 : (mode == 1 ? 18 : 35)))
            op = OP_PUSH;
         else if (pick < (mode == 0 ? 70 : (mode == 1 ? 60 : 58)))
            op = OP_POP;
         else if (pick < 82)
            op = OP_PEEK;
         else if (pick < 91)
            op = OP_TOP;
         else
            op = OP_BOTTOM;

         // Mostly arbitrary words, with the extremes mixed in.
         if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
               0: data = {1'b1, {(VALUE_W-1){1'b0}}};
               1: data = {1'b0, {(VALUE_W-1){1'b1}}};
               2: data = -1;
               default: data = '0;
            endcase
         end else begin
            data = $urandom;
         end

         // Peeks mostly land inside the stack; the rest cover the whole field.
         if (planned_fill > 0 && $urandom_range(99) < 80)
            position = POS_W'($urandom_range(planned_fill, 1));
         else
            position = POS_W'($urandom);

         queue_op(op, data, position);
      end
   endtask

   // Stimulus, reset and the end-of-run decision.
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_PUSH;
      req_data     = '0;
      req_position = '0;
      rsp_ready    = 1'b0;
      planned_fill = 0;
      shadow_fill  = 0;
      req_accepted = 0;
      error_count  = 0;
      req_taken    = 1'b0;
      holdoff_done = 1'b0;
      hold_left    = 0;
      quiet_cycles = 0;

      // Every error path on an empty stack first.
      queue_op(OP_POP, 32'sd5, 4'd1);
      queue_op(OP_TOP, 32'sd0, 4'd1);
      queue_op(OP_BOTTOM, 32'sd0, 4'd1);
      queue_op(OP_PEEK, 32'sd0, 4'd1);
      // Fill the stack with boundary words, then push once more to overflow.
      queue_op(OP_PUSH, 32'sh8000_0000, 4'd0);
      queue_op(OP_PUSH, 32'sh7FFF_FFFF, 4'd0);
      queue_op(OP_PUSH, -32'sd1, 4'd0);
      queue_op(OP_PUSH, 32'sd0, 4'd0);
      queue_op(OP_PUSH, 32'sd1, 4'd0);
      queue_op(OP_PUSH, 32'sh5555_5555, 4'd0);
      queue_op(OP_PUSH, 32'shAAAA_AAAA, 4'd0);
      queue_op(OP_PUSH, 32'sh1234_5678, 4'd0);
      queue_op(OP_PUSH, 32'shDEAD_BEEF, 4'd0);
      // Peeks at the deepest entry, just past it, at position zero and at the field maximum.
      queue_op(OP_PEEK, 32'sd0, 4'd8);
      queue_op(OP_PEEK, 32'sd0, 4'd9);
      queue_op(OP_PEEK, 32'sd0, 4'd0);
      queue_op(OP_PEEK, 32'sd0, 4'd15);
      queue_op(OP_TOP, 32'sd0, 4'd0);
      queue_op(OP_BOTTOM, 32'sd0, 4'd0);
      // Spare opcodes must leave everything untouched.
      queue_op(OP_SPARE_FIRST, 32'sh0F0F_0F0F, 4'd3);
      queue_op(OP_SPARE_LAST, -32'sd1, 4'd15);
      queue_op(OP_POP, 32'sd0, 4'd0);
      queue_op(OP_PEEK, 32'sd0, 4'd1);
      queue_op(OP_SPARE_FIRST + 3'd1, 32'sd7, 4'd2);
      queue_pause();
      queue_random_ops();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stack_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", awaited_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Request driver: presents the next pending transaction, idling at random.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (stack_requests.size() != 0 && stack_requests[0].drain_first &&
             awaited_results.size() == 0)
            void'(stack_requests.pop_front());
         if (stack_requests.size() != 0 && !stack_requests[0].drain_first &&
             (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_valid    <= 1'b1;
            req_op       <= stack_requests[0].op;
            req_data     <= stack_requests[0].data;
            req_position <= stack_requests[0].position;
            void'(stack_requests.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off that backs the stack up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!holdoff_done && req_accepted >= HOLDOFF_AT) begin
         holdoff_done <= 1'b1;
         hold_left    <= HOLDOFF_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted result.
   always @(posedge clock) begin
      stack_req_type req;
      stack_rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            req.op          = req_op;
            req.data        = req_data;
            req.position    = req_position;
            req.drain_first = 1'b0;
            awaited_results.push_back(apply_stack_op(req));
            req_accepted++;
         end

         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transaction with nothing expected: value %0d status %0d",
                      rsp_value, rsp_status);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_value);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_is_empty);
                  error_count++;
               end
               if (rsp_is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, rsp_is_full);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transaction accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
